@@ rtl/core/ptsa_pkg.sv @@
// ----------------------------------------------------------------------------
// ptsa_pkg
// shared types and constants for the pid and task slot allocator
// ----------------------------------------------------------------------------
package ptsa_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int ID_W      = 31;
    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 6;

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_OCCUPY  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE
    } t_state;

endpackage

@@ rtl/core/pid_and_task_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// pid_and_task_slot_allocator
// task slot table with a wrapping process id counter, id clash search and lowest
// free slot search from slot 1, run by a small sequencer over one shared compare
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  request  | in        | i_valid / o_stall  | i_command, i_slot
//  result   | out       | o_valid / i_stall  | o_status, o_slot_index,
//           |           |                    | o_process_id
//
//  occupy, release and no-op: result is registered at the accepting edge,
//  so it is offered in the next cycle
//  allocate: each id candidate is compared against the slot ids, one slot id
//  memory read per cycle through the registered read, restarted with the next
//  candidate on a clash, at most SLOTS+1 candidates; then the free slot scan
//  over slots 1 to SLOTS-1, one valid bit per cycle
//  reset: synchronous, slot 0 valid with id 0, counter zero, no clearing pass
//  a new request is taken only while idle and the result register is empty
//  or being emptied in the same cycle
//
module pid_and_task_slot_allocator #(
    parameter int SLOTS = ptsa_pkg::SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [ptsa_pkg::CMD_W-1:0]  i_command,
    input  logic [ptsa_pkg::SLOT_W-1:0] i_slot,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_status,
    output logic [ptsa_pkg::SLOT_W-1:0] o_slot_index,
    output logic [ptsa_pkg::ID_W-1:0]   o_process_id
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TRY_W = $clog2(SLOTS + 2);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [TRY_W-1:0] LAST_TRY = TRY_W'(SLOTS);

    // slot id storage, registered read
    logic [ptsa_pkg::ID_W-1:0] r_mem [SLOTS];
    logic [ptsa_pkg::ID_W-1:0] r_rd_data;

    ptsa_pkg::t_state r_state, n_state;

    logic [SLOTS-1:0]          r_valid, n_valid;
    logic                      r_id0_set, n_id0_set;   // slot 0 id written since reset
    logic [ptsa_pkg::ID_W-1:0] r_last_id, n_last_id;
    logic [TRY_W-1:0]          r_tries, n_tries;
    logic [IDX_W-1:0]          r_addr, n_addr;
    logic                      r_issue, n_issue;       // compare reads still to issue
    logic                      r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]          r_rd_idx, n_rd_idx;

    logic                      r_out_valid, n_out_valid;
    logic                      r_status, n_status;
    logic [ptsa_pkg::SLOT_W-1:0] r_slot_index, n_slot_index;
    logic [ptsa_pkg::ID_W-1:0]   r_process_id, n_process_id;

    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;

    logic                      out_free;
    logic                      accept;
    logic [IDX_W-1:0]          req_idx;
    logic                      req_in_range;
    logic [ptsa_pkg::ID_W-1:0] next_id;
    logic [ptsa_pkg::ID_W-1:0] cmp_id;
    logic                      clash;
    logic                      last_cmp;

    assign out_free     = !r_out_valid || !i_stall;
    assign o_stall      = !((r_state == ptsa_pkg::ST_IDLE) && out_free);
    assign accept       = i_valid && !o_stall;
    assign req_idx      = IDX_W'(i_slot);
    assign req_in_range = (32'(i_slot) < SLOTS);

    // shared incrementer with wrap to 1
    assign next_id = (r_last_id == ptsa_pkg::ID_MAX) ? ptsa_pkg::ID_W'(1)
                                                    : r_last_id + 1'b1;

    // shared compare: slot 0 reads as id 0 until first occupied
    assign cmp_id   = ((r_rd_idx == '0) && !r_id0_set) ? '0 : r_rd_data;
    assign clash    = r_rd_vld && r_valid[r_rd_idx] && (cmp_id == r_last_id);
    assign last_cmp = r_rd_vld && (r_rd_idx == LAST_IDX);

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_slot_index = r_slot_index;
    assign o_process_id = r_process_id;

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_id0_set    = r_id0_set;
        n_last_id    = r_last_id;
        n_tries      = r_tries;
        n_addr       = r_addr;
        n_issue      = r_issue;
        n_rd_vld     = 1'b0;
        n_rd_idx     = r_addr;
        n_out_valid  = r_out_valid && i_stall;
        n_status     = r_status;
        n_slot_index = r_slot_index;
        n_process_id = r_process_id;
        mem_we       = 1'b0;
        mem_waddr    = req_idx;

        case (r_state)
            ptsa_pkg::ST_IDLE: begin
                if (accept) begin
                    case (ptsa_pkg::t_cmd'(i_command))
                        ptsa_pkg::CMD_ALLOC: begin
                            n_last_id = next_id;
                            n_tries   = '0;
                            n_addr    = '0;
                            n_issue   = 1'b1;
                            n_state   = ptsa_pkg::ST_SCAN;
                        end
                        ptsa_pkg::CMD_OCCUPY: begin
                            if (req_in_range) begin
                                n_valid[req_idx] = 1'b1;
                                mem_we           = 1'b1;
                                if (req_idx == '0) begin
                                    n_id0_set = 1'b1;
                                end
                            end
                            n_out_valid  = 1'b1;
                            n_status     = 1'b0;
                            n_slot_index = i_slot;
                            n_process_id = r_last_id;
                        end
                        ptsa_pkg::CMD_RELEASE: begin
                            if (req_in_range) begin
                                n_valid[req_idx] = 1'b0;
                            end
                            n_out_valid  = 1'b1;
                            n_status     = 1'b0;
                            n_slot_index = i_slot;
                            n_process_id = r_last_id;
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_status     = 1'b0;
                            n_slot_index = i_slot;
                            n_process_id = r_last_id;
                        end
                    endcase
                end
            end

            ptsa_pkg::ST_SCAN: begin
                // issue one read per cycle
                if (r_issue) begin
                    n_rd_vld = 1'b1;
                    n_addr   = r_addr + 1'b1;
                    if (r_addr == LAST_IDX) begin
                        n_issue = 1'b0;
                    end
                end
                if (clash) begin
                    if (r_tries == LAST_TRY) begin
                        n_state  = ptsa_pkg::ST_FREE;
                        n_addr   = IDX_W'(1);
                        n_issue  = 1'b0;
                        n_rd_vld = 1'b0;
                    end else begin
                        // restart with the next candidate
                        n_last_id = next_id;
                        n_tries   = r_tries + 1'b1;
                        n_addr    = '0;
                        n_issue   = 1'b1;
                        n_rd_vld  = 1'b0;
                    end
                end else if (last_cmp) begin
                    n_state  = ptsa_pkg::ST_FREE;
                    n_addr   = IDX_W'(1);
                    n_issue  = 1'b0;
                    n_rd_vld = 1'b0;
                end
            end

            ptsa_pkg::ST_FREE: begin
                // result register is empty here: nothing was loaded for allocate
                if (!r_valid[r_addr]) begin
                    n_status     = 1'b0;
                    n_slot_index = ptsa_pkg::SLOT_W'(r_addr);
                    n_process_id = r_last_id;
                    n_out_valid  = 1'b1;
                    n_state      = ptsa_pkg::ST_IDLE;
                end else if (r_addr == LAST_IDX) begin
                    n_status     = 1'b1;
                    n_slot_index = '0;
                    n_process_id = r_last_id;
                    n_out_valid  = 1'b1;
                    n_state      = ptsa_pkg::ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end

            default: begin
                n_state = ptsa_pkg::ST_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptsa_pkg::ST_IDLE;
            r_valid     <= {{(SLOTS-1){1'b0}}, 1'b1};
            r_id0_set   <= 1'b0;
            r_last_id   <= '0;
            r_tries     <= '0;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_id0_set   <= n_id0_set;
            r_last_id   <= n_last_id;
            r_tries     <= n_tries;
            r_addr      <= n_addr;
            r_issue     <= n_issue;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_status     <= n_status;
        r_slot_index <= n_slot_index;
        r_process_id <= n_process_id;
    end

    // slot id memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_last_id;
        end
        r_rd_data <= r_mem[r_addr];
    end

endmodule
